>>> rtl/ring_queue_with_prefix_reverse_defines.svh
// ----------------------------------------------------------------------------
// ring queue with prefix reverse: assertion macros
// Same-cycle and next-cycle implication checks, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_PREFIX_REVERSE_DEFINES_SVH
`define RING_QUEUE_WITH_PREFIX_REVERSE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RQPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RQPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RQPR_ASSERT_NOW(label, clk, rst, ante, cons)
`define RQPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/rqpr_pkg.sv
// ----------------------------------------------------------------------------
// rqpr_pkg
// Shared constants and types of the ring queue with prefix reverse.
// ----------------------------------------------------------------------------
`default_nettype none

package rqpr_pkg;

   localparam int SLOTS_DEFAULT      = 512;
   localparam int ITEM_WIDTH_DEFAULT = 32;
   localparam int DATA_W             = 32;
   localparam int PREFIX_W           = 9;
   localparam int MODE_W             = 2;
   localparam int STATUS_W           = 2;
   localparam int WIDE_W             = 64;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_DEQUEUE = 2'd1,
      MODE_REVERSE = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEQ,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI
   } state_type;

endpackage

`default_nettype wire

>>> rtl/rqpr_ram.sv
// ----------------------------------------------------------------------------
// rqpr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rqpr_ram #(
   parameter int WIDTH = rqpr_pkg::ITEM_WIDTH_DEFAULT,
   parameter int DEPTH = rqpr_pkg::SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/ring_queue_with_prefix_reverse.sv
// enqueue, make empty and a reverse of fewer than two items: result in the cycle after transfer
// dequeue: ram read registered into ST_DEQ, then result registered; underflow result next cycle
// reverse of k' = min(k, occupancy) items: floor(k'/2) swaps of RD_LO, RD_HI, WR_LO, WR_HI
// a new request is taken once the previous one is done and the result slot is free
// synchronous reset empties the queue (head and tail at SLOTS-1); ring contents are not cleared
// ----------------------------------------------------------------------------
// ring_queue_with_prefix_reverse
// Circular queue keeping one slot free, with in-place reversal of the front
// items by swapping ring entries through a single ram.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_queue_with_prefix_reverse_defines.svh"

module ring_queue_with_prefix_reverse #(
   parameter int SLOTS      = rqpr_pkg::SLOTS_DEFAULT,
   parameter int ITEM_WIDTH = rqpr_pkg::ITEM_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [rqpr_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [rqpr_pkg::DATA_W-1:0]   req_write_data,
   input  wire logic [rqpr_pkg::PREFIX_W-1:0] req_prefix_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [rqpr_pkg::DATA_W-1:0]   rsp_read_data,
   output logic      [rqpr_pkg::STATUS_W-1:0] rsp_status,
   output logic                               rsp_empty_flag,
   output logic                               rsp_full_flag
);

   localparam int IDX_W    = $clog2(SLOTS);
   localparam int PREFIX_W = rqpr_pkg::PREFIX_W;
   localparam int SWAP_W   = PREFIX_W - 1;
   localparam int DATA_W   = rqpr_pkg::DATA_W;
   localparam int WIDE_W   = rqpr_pkg::WIDE_W;
   localparam int CMP_W    = (IDX_W + 1 > PREFIX_W) ? IDX_W + 1 : PREFIX_W;
   localparam int SUM_W    = CMP_W + 1;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
      logic [IDX_W-1:0] res;
      if (pos == IDX_W'(SLOTS - 1)) begin
         res = '0;
      end else begin
         res = pos + IDX_W'(1);
      end
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] pos);
      logic [IDX_W-1:0] res;
      if (pos == '0) begin
         res = IDX_W'(SLOTS - 1);
      end else begin
         res = pos - IDX_W'(1);
      end
      return res;
   endfunction

   rqpr_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [IDX_W-1:0]     hi_ff, hi_in;
   logic [SWAP_W-1:0]    swaps_ff, swaps_in;
   logic [ITEM_WIDTH-1:0] lo_data_ff, lo_data_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_read_data_ff, rsp_read_data_in;
   rqpr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_empty_ff, rsp_full_ff;
   logic                 rsp_load;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [ITEM_WIDTH-1:0] ram_wr_data;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [ITEM_WIDTH-1:0] ram_rd_data;

   logic                  req_fire;
   logic                  is_empty;
   logic                  is_full;
   logic [IDX_W:0]        held;
   logic [PREFIX_W-1:0]   k_eff;
   logic [SUM_W-1:0]      hi_sum;
   logic [IDX_W-1:0]      hi_start;
   logic [WIDE_W-1:0]     wr_wide;
   logic [WIDE_W-1:0]     rd_wide;

   rqpr_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (SLOTS)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == rqpr_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign is_empty  = head_ff == tail_ff;
   assign is_full   = head_ff == ring_next(tail_ff);

   // occupancy and clamped prefix length
   assign held   = {1'b0, tail_ff} - {1'b0, head_ff}
                 + ((tail_ff < head_ff) ? (IDX_W + 1)'(SLOTS) : '0);
   assign k_eff  = (CMP_W'(held) < CMP_W'(req_prefix_count)) ? PREFIX_W'(held)
                 : req_prefix_count;
   assign hi_sum = SUM_W'(head_ff) + SUM_W'(k_eff);
   assign hi_start = (hi_sum >= SUM_W'(SLOTS)) ? IDX_W'(hi_sum - SUM_W'(SLOTS))
                   : IDX_W'(hi_sum);

   assign wr_wide = WIDE_W'(req_write_data);
   assign rd_wide = WIDE_W'(ram_rd_data);

   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      swaps_in         = swaps_ff;
      lo_data_in       = lo_data_ff;
      rsp_load         = 1'b0;
      rsp_read_data_in = '0;
      rsp_status_in    = rqpr_pkg::STATUS_OK;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = lo_ff;
      ram_wr_data      = ram_rd_data;
      ram_rd_addr      = lo_ff;
      unique case (state_ff)
         rqpr_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (rqpr_pkg::mode_type'(req_mode))
                  rqpr_pkg::MODE_ENQUEUE: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_status_in = rqpr_pkg::STATUS_OVERFLOW;
                     end else begin
                        tail_in     = ring_next(tail_ff);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ring_next(tail_ff);
                        ram_wr_data = wr_wide[ITEM_WIDTH-1:0];
                     end
                  end
                  rqpr_pkg::MODE_DEQUEUE: begin
                     if (is_empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = rqpr_pkg::STATUS_UNDERFLOW;
                     end else begin
                        head_in     = ring_next(head_ff);
                        ram_rd_addr = ring_next(head_ff);
                        state_in    = rqpr_pkg::ST_DEQ;
                     end
                  end
                  rqpr_pkg::MODE_REVERSE: begin
                     if (k_eff < PREFIX_W'(2)) begin
                        rsp_load = 1'b1;
                     end else begin
                        lo_in    = ring_next(head_ff);
                        hi_in    = hi_start;
                        swaps_in = k_eff[PREFIX_W-1:1];
                        state_in = rqpr_pkg::ST_REV_RD_LO;
                     end
                  end
                  rqpr_pkg::MODE_CLEAR: begin
                     rsp_load = 1'b1;
                     head_in  = IDX_W'(SLOTS - 1);
                     tail_in  = IDX_W'(SLOTS - 1);
                  end
               endcase
            end
         end
         rqpr_pkg::ST_DEQ: begin
            rsp_load         = 1'b1;
            rsp_read_data_in = rd_wide[DATA_W-1:0];
            state_in         = rqpr_pkg::ST_IDLE;
         end
         rqpr_pkg::ST_REV_RD_LO: begin
            ram_rd_addr = lo_ff;
            state_in    = rqpr_pkg::ST_REV_RD_HI;
         end
         rqpr_pkg::ST_REV_RD_HI: begin
            ram_rd_addr = hi_ff;
            lo_data_in  = ram_rd_data;
            state_in    = rqpr_pkg::ST_REV_WR_LO;
         end
         rqpr_pkg::ST_REV_WR_LO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff;
            ram_wr_data = ram_rd_data;
            state_in    = rqpr_pkg::ST_REV_WR_HI;
         end
         rqpr_pkg::ST_REV_WR_HI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hi_ff;
            ram_wr_data = lo_data_ff;
            swaps_in    = swaps_ff - SWAP_W'(1);
            if (swaps_ff == SWAP_W'(1)) begin
               rsp_load = 1'b1;
               state_in = rqpr_pkg::ST_IDLE;
            end else begin
               lo_in    = ring_next(lo_ff);
               hi_in    = ring_prev(hi_ff);
               state_in = rqpr_pkg::ST_REV_RD_LO;
            end
         end
         default: begin
            state_in = rqpr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqpr_pkg::ST_IDLE;
         head_ff      <= IDX_W'(SLOTS - 1);
         tail_ff      <= IDX_W'(SLOTS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      swaps_ff   <= swaps_in;
      lo_data_ff <= lo_data_in;
      // flags as they stand after the operation
      if (rsp_load) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_empty_ff     <= head_in == tail_in;
         rsp_full_ff      <= head_in == ring_next(tail_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_empty_flag = rsp_empty_ff;
   assign rsp_full_flag  = rsp_full_ff;

   `RQPR_ASSERT_NOW(a_index_range, clock, reset, 1'b1, (head_ff <= IDX_W'(SLOTS - 1)) && (tail_ff <= IDX_W'(SLOTS - 1)))
   `RQPR_ASSERT_NOW(a_deq_slot_free, clock, reset, state_ff == rqpr_pkg::ST_DEQ, !rsp_valid_ff)
   `RQPR_ASSERT_NEXT(a_rev_keeps_ptrs, clock, reset, (state_ff != rqpr_pkg::ST_IDLE) && (state_ff != rqpr_pkg::ST_DEQ), $stable(head_ff) && $stable(tail_ff))
   `RQPR_ASSERT_NEXT(a_overflow_holds, clock, reset, req_fire && (req_mode == rqpr_pkg::MODE_ENQUEUE) && is_full, $stable(tail_ff) && $stable(head_ff))

endmodule

`default_nettype wire
